/* src/ci64_pkg.sv */
// ----------------------------------------------------------------------------
// ci64_pkg: shared types and constants of the checked 64-bit ALU
// Operation and status codes, payload structs and pipeline sizing.
// ----------------------------------------------------------------------------
package ci64_pkg;

    localparam int DataWidth = 64;
    // One quotient bit per pipeline stage of the divider.
    localparam int DivStages = DataWidth;
    // Stages before the divider: operand prep, multiply partials, multiply sum.
    localparam int PreStages = 3;
    localparam int Latency = PreStages + DivStages + 1;

    localparam logic [2:0] ACT_ADD = 3'd0;
    localparam logic [2:0] ACT_SUB = 3'd1;
    localparam logic [2:0] ACT_MUL = 3'd2;
    localparam logic [2:0] ACT_DIV = 3'd3;
    localparam logic [2:0] ACT_REM = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

    typedef struct packed {
        logic [2:0]  action;
        logic        is_signed;
        logic [63:0] left_operand;
        logic [63:0] right_operand;
    } ci64_req_t;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  status;
    } ci64_rsp_t;

endpackage

/* src/ci64_stream_if.sv */
// ----------------------------------------------------------------------------
// ci64_stream_if: valid/ready channel
// Carries one payload of a generic type with a source and a sink side.
// ----------------------------------------------------------------------------
interface ci64_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/checked_int64_alu.sv */
// ----------------------------------------------------------------------------
// checked_int64_alu: checked 64-bit integer ALU
// Add, subtract, multiply, divide and remainder with overflow and zero checks.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle while the output is not stalled.
// The pipeline depth is set by the restoring divider, which resolves one
// quotient bit per stage over 64 stages; the 64 by 64 multiplier takes two
// stages of 32 by 32 partial products and their sum, hidden behind it. All
// operations share the same pipeline, so results come out in order. When the
// output is stalled the whole pipeline holds and no new transaction is taken
// until the waiting result has left.
module checked_int64_alu
    import ci64_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ci64_stream_if.sink   in_ch,
    ci64_stream_if.source out_ch
);

    typedef struct packed {
        logic [2:0]  action;
        logic        is_signed;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] ma;
        logic [63:0] mb;
        logic        neg_q;
        logic        neg_r;
        logic [1:0]  early_status;
        logic [63:0] early_value;
        logic        early_done;
    } prep_t;

    // Pipeline advances whenever the output slice can take a new entry.
    logic adv;
    logic [Latency-1:0] vld_reg;

    // ---------------- stage 0: operand preparation and add/sub -------------
    prep_t p0_reg, p0_next;
    logic [64:0] sum, dif;
    logic [63:0] ra, rb;
    always_comb
    begin
        ra = in_ch.data.left_operand;
        rb = in_ch.data.right_operand;
        sum = {1'b0, ra} + {1'b0, rb};
        dif = {1'b0, ra} - {1'b0, rb};
        p0_next.action = in_ch.data.action;
        p0_next.is_signed = in_ch.data.is_signed;
        p0_next.a = ra;
        p0_next.b = rb;
        p0_next.ma = in_ch.data.is_signed && ra[63] ? 64'd0 - ra : ra;
        p0_next.mb = in_ch.data.is_signed && rb[63] ? 64'd0 - rb : rb;
        p0_next.neg_q = in_ch.data.is_signed && (ra[63] ^ rb[63]);
        p0_next.neg_r = in_ch.data.is_signed && ra[63];
        p0_next.early_status = ST_OK;
        p0_next.early_value = 64'd0;
        p0_next.early_done = 1'b1;
        case (in_ch.data.action)
            ACT_ADD:
            begin
                if (in_ch.data.is_signed ? ((ra[63] ~^ rb[63]) && (sum[63] != ra[63]))
                                         : sum[64])
                    p0_next.early_status = ST_OVF;
                else
                    p0_next.early_value = sum[63:0];
            end
            ACT_SUB:
            begin
                if (in_ch.data.is_signed ? ((ra[63] ^ rb[63]) && (dif[63] != ra[63]))
                                         : dif[64])
                    p0_next.early_status = ST_OVF;
                else
                    p0_next.early_value = dif[63:0];
            end
            ACT_MUL: p0_next.early_done = 1'b0;
            ACT_DIV, ACT_REM:
            begin
                if (rb == 64'd0)
                    p0_next.early_status = ST_DIV0;
                else if (in_ch.data.is_signed && ra == SIGN_BIT && rb == '1)
                    p0_next.early_status = ST_OVF;
                else
                    p0_next.early_done = 1'b0;
            end
            default: ;
        endcase
    end

    // ---------------- stage 1: partial products -----------------------------
    prep_t p1_reg;
    logic [63:0] pll_reg, plh_reg, phl_reg, phh_reg;

    // ---------------- stage 2: product sum ----------------------------------
    prep_t p2_reg;
    logic [127:0] prod;
    logic [63:0]  mul_value;
    logic [1:0]   mul_status;
    logic [63:0]  p2_value_reg;
    logic [1:0]   p2_status_reg;
    always_comb
    begin
        prod = {64'd0, pll_reg} + {32'd0, plh_reg, 32'd0} + {32'd0, phl_reg, 32'd0}
             + {phh_reg, 64'd0};
        mul_value = 64'd0;
        mul_status = ST_OK;
        if (!p1_reg.is_signed)
        begin
            if (prod[127:64] != 64'd0) mul_status = ST_OVF;
            else mul_value = prod[63:0];
        end
        else if (prod[127:64] != 64'd0
                 || prod[63:0] > (p1_reg.neg_q ? SIGN_BIT : SIGN_BIT - 64'd1))
            mul_status = ST_OVF;
        else
            mul_value = p1_reg.neg_q ? 64'd0 - prod[63:0] : prod[63:0];
    end

    // ---------------- divider stages: one quotient bit each -----------------
    prep_t       dv_ctl_reg [DivStages+1];
    logic [63:0] dv_rem_reg [DivStages+1];
    logic [63:0] dv_quo_reg [DivStages+1];
    logic [63:0] dv_val_reg [DivStages+1];
    logic [1:0]  dv_st_reg  [DivStages+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Latency-2:0], in_ch.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_reg <= p0_next;
            p1_reg <= p0_reg;
            pll_reg <= p0_reg.ma[31:0] * p0_reg.mb[31:0];
            plh_reg <= p0_reg.ma[31:0] * p0_reg.mb[63:32];
            phl_reg <= p0_reg.ma[63:32] * p0_reg.mb[31:0];
            phh_reg <= p0_reg.ma[63:32] * p0_reg.mb[63:32];
            p2_reg <= p1_reg;
            p2_value_reg <= p1_reg.action == ACT_MUL ? mul_value : p1_reg.early_value;
            p2_status_reg <= p1_reg.action == ACT_MUL ? mul_status : p1_reg.early_status;
        end
    end

    always_comb
    begin
        dv_ctl_reg[0] = p2_reg;
        dv_rem_reg[0] = 64'd0;
        dv_quo_reg[0] = p2_reg.ma;
        dv_val_reg[0] = p2_value_reg;
        dv_st_reg[0]  = p2_status_reg;
    end

    for (genvar s = 0; s < DivStages; s++)
    begin : g_div
        logic [64:0] trial;
        logic [63:0] shifted;
        assign shifted = {dv_rem_reg[s][62:0], dv_quo_reg[s][63]};
        assign trial = {dv_rem_reg[s][63], shifted} - {1'b0, dv_ctl_reg[s].mb};
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_ctl_reg[s+1] <= dv_ctl_reg[s];
                dv_val_reg[s+1] <= dv_val_reg[s];
                dv_st_reg[s+1]  <= dv_st_reg[s];
                dv_rem_reg[s+1] <= trial[64] ? shifted : trial[63:0];
                dv_quo_reg[s+1] <= {dv_quo_reg[s][62:0], ~trial[64]};
            end
        end
    end

    // ---------------- final select -------------------------------------------
    ci64_rsp_t fin;
    prep_t fc;
    always_comb
    begin
        fc = dv_ctl_reg[DivStages];
        fin.value = dv_val_reg[DivStages];
        fin.status = dv_st_reg[DivStages];
        if (!fc.early_done && fc.action == ACT_DIV)
            fin.value = fc.neg_q ? 64'd0 - dv_quo_reg[DivStages] : dv_quo_reg[DivStages];
        else if (!fc.early_done && fc.action == ACT_REM)
            fin.value = fc.neg_r ? 64'd0 - dv_rem_reg[DivStages] : dv_rem_reg[DivStages];
    end

    // Output slice: last valid bit is the slice's own occupancy.
    ci64_rsp_t out_reg;
    assign adv = !vld_reg[Latency-1] || out_ch.ready;

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= fin;
    end

    assign in_ch.ready = adv;
    assign out_ch.valid = vld_reg[Latency-1];
    assign out_ch.data = out_reg;

endmodule

/* src/ci64_checker.sv */
// ----------------------------------------------------------------------------
// ci64_checker: port-level checks of the checked 64-bit ALU
// Watches the channels only, bound to the top level.
// ----------------------------------------------------------------------------
module ci64_checker
    import ci64_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input ci64_rsp_t out_data
);

    // A failed result carries zero.
    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.value == 64'd0)
        else $error("non-zero value on failed result");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.status != 2'd3)
        else $error("undefined status code");

    // The input is only held back while a result waits to be taken.
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("input stalled with free output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled transaction changed");

endmodule

bind checked_int64_alu ci64_checker u_ci64_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
